// ===== src/rmd_pkg.sv =====
// Package for the rounded multiply-divide block.
// Holds field widths and the divider pipeline payload type; no dependencies.
package rmd_pkg;

    localparam int unsigned FIELD_W = 32;               // width of every data field
    localparam int unsigned QUO_W   = FIELD_W - 1;      // quotient magnitude bits
    localparam int unsigned NUM_W   = 2 * FIELD_W - 1;  // rounded product magnitude bits

    typedef logic signed [FIELD_W-1:0] t_word;

    typedef struct packed {
        logic [FIELD_W-1:0] rem;    // partial remainder, below dmag when no overflow
        logic [QUO_W-1:0]   low;    // dividend bits not yet shifted in, MSB first
        logic [QUO_W-1:0]   quo;    // quotient bits developed so far
        logic [FIELD_W-1:0] dmag;   // divisor magnitude
        logic               neg;    // result is negative
        logic               fail;   // zero divisor or quotient out of range
    } t_div;

endpackage

// ===== src/rmd_if.sv =====
// Valid/ready channel interfaces for the rounded multiply-divide block.
// Depends on rmd_pkg for the field type.
interface rmd_in_if;
    import rmd_pkg::*;

    logic  valid;
    logic  ready;
    t_word multiplicand;
    t_word multiplier;
    t_word divisor;

    modport source (output valid, output multiplicand, output multiplier, output divisor,
                    input ready);
    modport sink   (input valid, input multiplicand, input multiplier, input divisor,
                    output ready);
endinterface

interface rmd_out_if;
    import rmd_pkg::*;

    logic  valid;
    logic  ready;
    t_word quotient;
    logic  failed;

    modport source (output valid, output quotient, output failed, input ready);
    modport sink   (input valid, input quotient, input failed, output ready);
endinterface

// ===== src/rmd_div_stage.sv =====
// One registered stage of the restoring divider: develops NBITS quotient bits.
// Depends on rmd_pkg for the t_div payload.
module rmd_div_stage #(
    parameter int unsigned NBITS = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  rmd_pkg::t_div i_div,
    output logic          o_vld,
    output rmd_pkg::t_div o_div
);
    import rmd_pkg::*;

    t_div n_div;
    t_div r_div;
    logic r_vld;

    always_comb begin
        logic [FIELD_W:0] trial;
        n_div = i_div;
        for (int unsigned k = 0; k < NBITS; k++) begin
            trial = {n_div.rem, n_div.low[QUO_W-1]};
            n_div.low = {n_div.low[QUO_W-2:0], 1'b0};
            if (trial >= {1'b0, n_div.dmag}) begin
                n_div.rem = FIELD_W'(trial - {1'b0, n_div.dmag});
                n_div.quo = {n_div.quo[QUO_W-2:0], 1'b1};
            end else begin
                n_div.rem = trial[FIELD_W-1:0];
                n_div.quo = {n_div.quo[QUO_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= n_div;
        end
    end

    assign o_vld = r_vld;
    assign o_div = r_div;

endmodule

// ===== src/rounded_multiply_divide.sv =====
// Rounded multiply-divide top level: (a * b +/- d/2) / d with range check.
// Depends on rmd_pkg, rmd_if and rmd_div_stage.
//
//  channel  dir  payload                                  handshake
//  i_in     in   multiplicand, multiplier, divisor (s32)  valid/ready
//  o_out    out  quotient (s32), failed                   valid/ready
//
// One transaction per cycle sustained unless the output stalls; operands pass
// the magnitude, product, rounding, setup, divider-stage and output registers.
// Reset clears only the stage valid bits; i_in.ready is low while in reset.
// A stalled output holds the whole pipeline; i_in.ready follows that stall.
module rounded_multiply_divide #(
    parameter int unsigned DIV_BITS_PER_STAGE = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rmd_in_if.sink    i_in,
    rmd_out_if.source o_out
);
    import rmd_pkg::*;

    localparam int unsigned NSTG = (QUO_W + DIV_BITS_PER_STAGE - 1) / DIV_BITS_PER_STAGE;

    logic en;

    // stage 1: magnitudes and result sign
    logic [FIELD_W-1:0] r_amag, r_bmag, r_dmag1;
    logic               r_neg1, r_zero1, r_vld1;
    // stage 2: product
    logic [NUM_W-1:0]   r_prod;
    logic [FIELD_W-1:0] r_dmag2;
    logic               r_neg2, r_zero2, r_vld2;
    // stage 3: rounded dividend
    logic [NUM_W-1:0]   r_num;
    logic [FIELD_W-1:0] r_dmag3;
    logic               r_neg3, r_zero3, r_vld3;
    // stage 4: overflow check, divider setup
    t_div               r_div4;
    logic               r_vld4;
    // output
    t_word              r_quo;
    logic               r_fail, r_vld_out;

    logic [FIELD_W-1:0] n_amag, n_bmag, n_dmag;
    logic               n_aneg;
    logic [2*FIELD_W-1:0] n_prod;
    t_div               n_div4;
    t_word              n_quo;

    t_div w_div [0:NSTG];
    logic w_vld [0:NSTG];

    assign en = !r_vld_out || o_out.ready;
    assign i_in.ready = en && i_rst_n;

    assign n_amag = i_in.multiplicand[FIELD_W-1] ? $unsigned(-i_in.multiplicand)
                                                 : $unsigned(i_in.multiplicand);
    assign n_bmag = i_in.multiplier[FIELD_W-1] ? $unsigned(-i_in.multiplier)
                                               : $unsigned(i_in.multiplier);
    assign n_dmag = i_in.divisor[FIELD_W-1] ? $unsigned(-i_in.divisor)
                                            : $unsigned(i_in.divisor);
    // multiplicand sign after the divisor sign fix
    assign n_aneg = i_in.divisor[FIELD_W-1] ? (i_in.multiplicand > 0)
                                            : i_in.multiplicand[FIELD_W-1];

    assign n_prod = r_amag * r_bmag;

    always_comb begin
        n_div4.rem  = r_num[NUM_W-1:QUO_W];
        n_div4.low  = r_num[QUO_W-1:0];
        n_div4.quo  = '0;
        n_div4.dmag = r_dmag3;
        n_div4.neg  = r_neg3;
        n_div4.fail = r_zero3 || (r_num[NUM_W-1:QUO_W] >= r_dmag3);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1    <= 1'b0;
            r_vld2    <= 1'b0;
            r_vld3    <= 1'b0;
            r_vld4    <= 1'b0;
            r_vld_out <= 1'b0;
        end else if (en) begin
            r_vld1    <= i_in.valid;
            r_vld2    <= r_vld1;
            r_vld3    <= r_vld2;
            r_vld4    <= r_vld3;
            r_vld_out <= w_vld[NSTG];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_amag  <= n_amag;
            r_bmag  <= n_bmag;
            r_dmag1 <= n_dmag;
            r_neg1  <= n_aneg ^ i_in.multiplier[FIELD_W-1];
            r_zero1 <= (i_in.divisor == '0);

            r_prod  <= n_prod[NUM_W-1:0];
            r_dmag2 <= r_dmag1;
            r_neg2  <= r_neg1;
            r_zero2 <= r_zero1;

            r_num   <= r_prod + NUM_W'(r_dmag2[FIELD_W-1:1]);
            r_dmag3 <= r_dmag2;
            r_neg3  <= r_neg2;
            r_zero3 <= r_zero2;

            r_div4  <= n_div4;

            r_quo   <= n_quo;
            r_fail  <= w_div[NSTG].fail;
        end
    end

    assign w_div[0] = r_div4;
    assign w_vld[0] = r_vld4;

    generate
        for (genvar g = 0; g < NSTG; g++) begin : g_div
            localparam int unsigned NB = (g == NSTG - 1)
                ? QUO_W - (NSTG - 1) * DIV_BITS_PER_STAGE : DIV_BITS_PER_STAGE;
            rmd_div_stage #(
                .NBITS (NB)
            ) u_stage (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (en),
                .i_vld   (w_vld[g]),
                .i_div   (w_div[g]),
                .o_vld   (w_vld[g+1]),
                .o_div   (w_div[g+1])
            );
        end
    endgenerate

    always_comb begin
        if (w_div[NSTG].fail) begin
            n_quo = '1;
        end else if (w_div[NSTG].neg) begin
            n_quo = -$signed({1'b0, w_div[NSTG].quo});
        end else begin
            n_quo = $signed({1'b0, w_div[NSTG].quo});
        end
    end

    assign o_out.valid    = r_vld_out;
    assign o_out.quotient = r_quo;
    assign o_out.failed   = r_fail;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for rounded_multiply_divide: directed table, then shaped random transactions.
// Expected values: table or 64-bit behavioral predictor; needs rmd_pkg and rmd_if.
module tb_top;
    import rmd_pkg::*;

    localparam real    CLK_HALF         = 6.0;
    localparam int     RESET_CYCLES     = 5;
    localparam int     RANDOM_PER_PHASE = 340;
    localparam int     NUM_PHASES       = 4;
    localparam int     DRAIN_LIMIT      = 20000;
    localparam int     TAIL_CYCLES      = 24;
    localparam int     DIRECTED_ROWS    = 25;

    localparam t_word  W_MIN     = 32'sh8000_0000;
    localparam t_word  W_MAX     = 32'sh7FFF_FFFF;
    localparam t_word  FAIL_WORD = -32'sd1;
    localparam longint Q_HI      = 64'sd2147483647;
    localparam longint Q_LO      = -64'sd2147483647;

    typedef struct {
        t_word quotient;
        logic  failed;
    } t_quo;

    typedef struct {
        t_word multiplicand;
        t_word multiplier;
        t_word divisor;
        bit    known;
        t_word quotient;
        logic  failed;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    rmd_in_if  in_ch ();
    rmd_out_if out_ch ();

    rounded_multiply_divide uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    t_quo        pending_quotients[$];
    int unsigned idle_pct  = 0;
    int unsigned stall_pct = 0;
    int          mismatches = 0;
    int          n_sent = 0;
    int          n_results = 0;
    int          n_flagged = 0;

    t_dir_row directed_rows [DIRECTED_ROWS] = '{
        '{32'sd0,  32'sd0,  32'sd0,  1'b1, FAIL_WORD, 1'b1},
        '{32'sd1,  32'sd1,  32'sd1,  1'b1, 32'sd1,    1'b0},
        '{-32'sd1, 32'sd1,  32'sd1,  1'b1, FAIL_WORD, 1'b0},
        '{32'sd5,  32'sd5,  32'sd0,  1'b1, FAIL_WORD, 1'b1},
        '{W_MIN,   32'sd1,  32'sd1,  1'b1, FAIL_WORD, 1'b1},
        '{W_MAX,   32'sd1,  32'sd1,  1'b1, W_MAX,     1'b0},
        '{-W_MAX,  32'sd1,  32'sd1,  1'b1, -W_MAX,    1'b0},
        '{W_MAX,   W_MAX,   32'sd1,  1'b1, FAIL_WORD, 1'b1},
        '{W_MIN,   W_MIN,   32'sd1,  1'b1, FAIL_WORD, 1'b1},
        '{W_MAX,   W_MAX,   32'sd0,  1'b1, FAIL_WORD, 1'b1},
        '{32'sd3,  32'sd1,  32'sd2,  1'b0, 32'sd0,    1'b0},
        '{-32'sd3, 32'sd1,  32'sd2,  1'b0, 32'sd0,    1'b0},
        '{32'sd3,  32'sd1,  -32'sd2, 1'b0, 32'sd0,    1'b0},
        '{-32'sd3, -32'sd1, -32'sd2, 1'b0, 32'sd0,    1'b0},
        '{32'sd5,  32'sd1,  32'sd4,  1'b0, 32'sd0,    1'b0},
        '{32'sd7,  32'sd3,  32'sd2,  1'b0, 32'sd0,    1'b0},
        '{32'sd2,  32'sd1,  32'sd3,  1'b0, 32'sd0,    1'b0},
        '{32'sd0,  W_MIN,   32'sd5,  1'b0, 32'sd0,    1'b0},
        '{W_MIN,   W_MIN,   W_MIN,   1'b0, 32'sd0,    1'b0},
        '{W_MIN,   -32'sd1, -32'sd1, 1'b0, 32'sd0,    1'b0},
        '{W_MIN,   32'sd1,  -32'sd1, 1'b0, 32'sd0,    1'b0},
        '{W_MAX,   W_MAX,   W_MAX,   1'b0, 32'sd0,    1'b0},
        '{W_MAX,   W_MAX,   W_MIN,   1'b0, 32'sd0,    1'b0},
        '{-32'sd1, -32'sd1, W_MIN,   1'b0, 32'sd0,    1'b0},
        '{32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0F0F_0F0F, 1'b0, 32'sd0, 1'b0}
    };

    // product kept at 64 bits; rounding half away from zero, then truncation
    function automatic t_quo muldiv_round(t_word a, t_word b, t_word d);
        longint ma;
        longint mb;
        longint md;
        longint prod;
        longint half;
        longint q;
        t_quo   r;
        ma = a;
        mb = b;
        md = d;
        r.quotient = FAIL_WORD;
        r.failed   = 1'b1;
        if (md == 0)
            return r;
        if (md < 0) begin
            ma = -ma;
            md = -md;
        end
        prod = ma * mb;
        half = md / 2;
        if ((ma < 0) == (mb < 0))
            q = (prod + half) / md;
        else
            q = (prod - half) / md;
        if (q > Q_HI || q < Q_LO)
            return r;
        r.quotient = t_word'(q);
        r.failed   = 1'b0;
        return r;
    endfunction

    function automatic t_word shaped_word();
        int unsigned sel;
        t_word       raw;
        sel = $urandom_range(15);
        raw = $urandom;
        case (sel)
            0: return W_MIN;
            1: return W_MAX;
            2: return 32'sd0;
            3: return 32'sd1;
            4: return -32'sd1;
            5, 6, 7: return raw;
            default: return raw >>> $urandom_range(31, 1);
        endcase
    endfunction

    task automatic send_operands(t_word a, t_word b, t_word d, bit known, t_quo typed);
        t_quo want;
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            in_ch.valid        <= 1'b0;
            in_ch.multiplicand <= $urandom;
            in_ch.multiplier   <= $urandom;
            in_ch.divisor      <= $urandom;
            @(negedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.multiplicand <= a;
        in_ch.multiplier   <= b;
        in_ch.divisor      <= d;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        want = known ? typed : muldiv_round(a, b, d);
        pending_quotients.push_back(want);
        n_sent++;
    endtask

    task automatic send_random();
        int unsigned sel;
        t_word       a;
        t_word       b;
        t_word       d;
        t_quo        none;
        sel = $urandom_range(9);
        none = '{32'sd0, 1'b0};
        case (sel)
            0: begin
                a = $urandom;
                b = $urandom;
                d = $urandom;
            end
            1: begin
                a = shaped_word();
                b = shaped_word();
                d = 32'sd0;
            end
            2: begin
                // operands near the range limits
                a = shaped_word();
                b = $urandom_range(1, 2);
                d = $urandom_range(1, 3);
                if ($urandom_range(1))
                    b = -b;
                if ($urandom_range(1))
                    d = -d;
            end
            default: begin
                a = shaped_word();
                b = shaped_word();
                d = shaped_word();
            end
        endcase
        send_operands(a, b, d, 1'b0, none);
    endtask

    always @(negedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        t_quo want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            n_results++;
            if (out_ch.failed)
                n_flagged++;
            if (pending_quotients.size() == 0) begin
                $error("unexpected result: quotient %0d failed %0b", out_ch.quotient,
                       out_ch.failed);
                mismatches++;
            end else begin
                want = pending_quotients.pop_front();
                if (out_ch.quotient !== want.quotient) begin
                    $error("quotient: expected %0d, actual %0d", want.quotient,
                           out_ch.quotient);
                    mismatches++;
                end
                if (out_ch.failed !== want.failed) begin
                    $error("failed: expected %0b, actual %0b", want.failed, out_ch.failed);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #5ms;
        $display("timeout with %0d transactions outstanding", pending_quotients.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int          drain;
        int unsigned phase_idle  [NUM_PHASES];
        int unsigned phase_stall [NUM_PHASES];
        t_quo        typed;
        phase_idle         = '{0, 83, 0, 33};
        phase_stall        = '{0, 0, 83, 33};
        in_ch.valid        = 1'b0;
        in_ch.multiplicand = '0;
        in_ch.multiplier   = '0;
        in_ch.divisor      = '0;
        out_ch.ready       = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            typed = '{directed_rows[i].quotient, directed_rows[i].failed};
            send_operands(directed_rows[i].multiplicand, directed_rows[i].multiplier,
                          directed_rows[i].divisor, directed_rows[i].known, typed);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            idle_pct  = phase_idle[p];
            stall_pct = phase_stall[p];
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                send_random();
        end
        @(negedge i_clk);
        in_ch.valid <= 1'b0;

        drain = 0;
        while (pending_quotients.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        if (pending_quotients.size() != 0) begin
            $error("%0d transactions never returned", pending_quotients.size());
            mismatches++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("%0d transactions sent (%0d from the directed table), %0d results checked",
                 n_sent, DIRECTED_ROWS, n_results);
        $display("%0d results flagged as failed, %0d mismatches", n_flagged, mismatches);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
